// ----- sv/limit_order_book_engine_unit_assert.svh -----
// ----------------------------------------------------------------------------
// limit_order_book_engine_unit_assert
// assertion macros for the order book engine
// ----------------------------------------------------------------------------
`ifndef LIMIT_ORDER_BOOK_ENGINE_UNIT_ASSERT_SVH
`define LIMIT_ORDER_BOOK_ENGINE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define LOB_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LOB_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LOB_ASSERT(label, clk, rst_n, prop, msg)
`define LOB_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ----- sv/lobe_pkg.sv -----
// ----------------------------------------------------------------------------
// lobe_pkg
// types and constants shared by the order book engine modules
// ----------------------------------------------------------------------------
package lobe_pkg;
	localparam int MaxOrders = 256;
	localparam int PriceBits = 24;
	localparam int SlotBits = $clog2(MaxOrders);
	localparam int CntBits = $clog2(MaxOrders + 1);
	localparam int ArrBits = 48;

	typedef logic [SlotBits-1:0] slot_t;
	typedef logic [CntBits-1:0] cnt_t;
	typedef logic signed [PriceBits-1:0] price_t;
	typedef logic signed [PriceBits:0] spread_t;
	typedef logic [ArrBits-1:0] arr_t;

	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_CANCEL = 2'd1;
	localparam logic [1:0] CMD_MODIFY = 2'd2;
	localparam logic [1:0] CMD_QUERY = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_DUP = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_NEG_PRICE = 3'd3;
	localparam logic [2:0] ST_ZERO_QTY = 3'd4;
	localparam logic [2:0] ST_FULL = 3'd5;

	// controller to datapath
	typedef struct packed {
		logic load;      // latch request
		logic scan_clr;  // clear scan results
		logic scan_en;   // examine entry at scan index
		logic apply;     // write the command result
		logic best_clr;
		logic best_en;
		logic emit;
	} lobe_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
		logic best_last;
	} lobe_sts_t;
endpackage

// ----- sv/lobe_ctrl.sv -----
// ----------------------------------------------------------------------------
// lobe_ctrl
// sequencer: lookup scan, update, best-price scan, result
// ----------------------------------------------------------------------------
module lobe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output lobe_pkg::lobe_ctl_t ctl,
	input  lobe_pkg::lobe_sts_t sts
);
	import lobe_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SCAN  = 6'b000010,
		S_APPLY = 6'b000100,
		S_BEST  = 6'b001000,
		S_DRAIN = 6'b010000,
		S_EMIT  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		ctl = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					ctl.scan_clr = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				ctl.scan_en = 1'b1;
				if (sts.scan_last) state_d = S_APPLY;
			end
			S_APPLY: begin
				ctl.apply = 1'b1;
				ctl.best_clr = 1'b1;
				state_d = S_BEST;
			end
			S_BEST: begin
				ctl.best_en = 1'b1;
				if (sts.best_last) state_d = S_DRAIN;
			end
			// memory read latency: last entry is compared here
			S_DRAIN: begin
				ctl.best_en = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				ctl.emit = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);
endmodule

// ----- sv/lobe_dp.sv -----
// ----------------------------------------------------------------------------
// lobe_dp
// order table, lookup scan and best bid / best ask scan
// ----------------------------------------------------------------------------
module lobe_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lobe_pkg::lobe_ctl_t   ctl,
	output lobe_pkg::lobe_sts_t   sts,
	input  logic [1:0]            cmd,
	input  logic [31:0]           req_id,
	input  logic                  side,
	input  lobe_pkg::price_t      price,
	input  logic [31:0]           quantity,
	output logic                  done,
	output logic [2:0]            status,
	output lobe_pkg::price_t      best_bid_price,
	output lobe_pkg::price_t      best_ask_price,
	output lobe_pkg::spread_t     spread_ticks,
	output logic                  bid_present,
	output logic                  ask_present,
	output logic [31:0]           best_bid_id,
	output logic [31:0]           best_ask_id,
	output logic                  found_side,
	output lobe_pkg::price_t      found_price,
	output logic [31:0]           found_quantity
);
	import lobe_pkg::*;

	// request registers
	logic [1:0]  cmd_q;
	logic [31:0] id_q;
	logic        side_q;
	price_t      price_q;
	logic [31:0] qty_q;

	logic [MaxOrders-1:0] valid_q;
	logic [31:0] mem_id [MaxOrders];
	logic        mem_side [MaxOrders];
	price_t      mem_price [MaxOrders];
	logic [31:0] mem_qty [MaxOrders];
	arr_t        mem_arr [MaxOrders];

	arr_t  arr_cnt_q;
	cnt_t  idx_q;        // scan address
	slot_t sidx_q;       // slot of registered read data
	logic  rd_v_q;       // read data valid this cycle

	logic [31:0] rd_id_q, rd_qty_q;
	logic        rd_side_q;
	price_t      rd_price_q;
	arr_t        rd_arr_q;

	logic  hit_q, free_ok_q;
	slot_t hit_slot_q, free_slot_q;
	logic  scan_phase;

	// best trackers
	logic   bb_v_q, ba_v_q;
	price_t bb_p_q, ba_p_q;
	arr_t   bb_a_q, ba_a_q;
	logic [31:0] bb_id_q, ba_id_q;
	logic   f_v_q, f_side_q;
	price_t f_p_q;
	logic [31:0] f_qty_q;
	logic [2:0] st_q;

	slot_t rd_addr;
	assign rd_addr = idx_q[SlotBits-1:0];
	assign sts.scan_last = rd_v_q && (sidx_q == slot_t'(MaxOrders - 1));
	assign sts.best_last = (idx_q == cnt_t'(MaxOrders - 1));
	assign scan_phase = ctl.scan_en;

	// write decode
	logic        wr_en, wr_new, wr_stamp;
	slot_t       wr_slot;
	logic [2:0]  st_d;
	always_comb begin
		wr_en = 1'b0;
		wr_new = 1'b0;
		wr_stamp = 1'b0;
		wr_slot = hit_slot_q;
		st_d = ST_OK;
		unique case (cmd_q)
			CMD_ADD: begin
				if (hit_q) st_d = ST_DUP;
				else if (!free_ok_q) st_d = ST_FULL;
				else begin
					wr_en = 1'b1; wr_new = 1'b1; wr_stamp = 1'b1;
					wr_slot = free_slot_q;
				end
			end
			CMD_CANCEL: if (!hit_q) st_d = ST_NOT_FOUND;
			CMD_MODIFY: begin
				if (price_q < 0) st_d = ST_NEG_PRICE;
				else if (qty_q == '0) st_d = ST_ZERO_QTY;
				else if (!hit_q) st_d = ST_NOT_FOUND;
				else begin
					wr_en = 1'b1;
					wr_stamp = (f_p_q != price_q);
				end
			end
			CMD_QUERY: if (!hit_q) st_d = ST_NOT_FOUND;
			default: st_d = ST_OK;
		endcase
	end

	// memory: one write and one registered read
	always_ff @(posedge clk) begin
		if (ctl.apply && wr_en) begin
			if (wr_new) begin
				mem_id[wr_slot] <= id_q;
				mem_side[wr_slot] <= side_q;
			end
			mem_price[wr_slot] <= price_q;
			mem_qty[wr_slot] <= qty_q;
			if (wr_stamp) mem_arr[wr_slot] <= arr_cnt_q;
		end
		rd_id_q <= mem_id[rd_addr];
		rd_side_q <= mem_side[rd_addr];
		rd_price_q <= mem_price[rd_addr];
		rd_qty_q <= mem_qty[rd_addr];
		rd_arr_q <= mem_arr[rd_addr];
	end

	logic rd_live;
	assign rd_live = rd_v_q && valid_q[sidx_q];

	logic bb_better, ba_better;
	always_comb begin
		bb_better = !bb_v_q || (rd_price_q > bb_p_q) ||
			(rd_price_q == bb_p_q && rd_arr_q < bb_a_q);
		ba_better = !ba_v_q || (rd_price_q < ba_p_q) ||
			(rd_price_q == ba_p_q && rd_arr_q < ba_a_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			arr_cnt_q <= '0;
			idx_q <= '0;
			rd_v_q <= 1'b0;
			sidx_q <= '0;
			hit_q <= 1'b0;
			free_ok_q <= 1'b0;
			bb_v_q <= 1'b0;
			ba_v_q <= 1'b0;
			f_v_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= ctl.emit;
			rd_v_q <= 1'b0;
			if (ctl.scan_clr) begin
				idx_q <= '0;
				hit_q <= 1'b0;
				free_ok_q <= 1'b0;
				f_v_q <= 1'b0;
			end
			if (ctl.scan_en || ctl.best_en) begin
				if (idx_q != cnt_t'(MaxOrders)) begin
					idx_q <= idx_q + cnt_t'(1);
					rd_v_q <= 1'b1;
					sidx_q <= rd_addr;
				end
			end
			if (scan_phase && rd_live && !hit_q && rd_id_q == id_q) begin
				hit_q <= 1'b1;
				f_p_q <= rd_price_q;
			end
			if (scan_phase && rd_v_q && !valid_q[sidx_q] && !free_ok_q) begin
				free_ok_q <= 1'b1;
			end
			if (ctl.apply) begin
				st_q <= st_d;
				idx_q <= '0;
				if (wr_en && wr_stamp) arr_cnt_q <= arr_cnt_q + arr_t'(1);
				if (wr_en && wr_new) valid_q[wr_slot] <= 1'b1;
				if (cmd_q == CMD_CANCEL && hit_q) valid_q[hit_slot_q] <= 1'b0;
			end
			if (ctl.best_clr) begin
				bb_v_q <= 1'b0;
				ba_v_q <= 1'b0;
				f_v_q <= 1'b0;
			end
			if (ctl.best_en && rd_live) begin
				if (!rd_side_q && bb_better) begin
					bb_v_q <= 1'b1; bb_p_q <= rd_price_q;
					bb_a_q <= rd_arr_q; bb_id_q <= rd_id_q;
				end
				if (rd_side_q && ba_better) begin
					ba_v_q <= 1'b1; ba_p_q <= rd_price_q;
					ba_a_q <= rd_arr_q; ba_id_q <= rd_id_q;
				end
				if (!f_v_q && rd_id_q == id_q) begin
					f_v_q <= 1'b1; f_side_q <= rd_side_q;
					f_p_q <= rd_price_q; f_qty_q <= rd_qty_q;
				end
			end
		end
	end

	// slot captures, payload only
	always_ff @(posedge clk) begin
		if (scan_phase && rd_live && !hit_q && rd_id_q == id_q) hit_slot_q <= sidx_q;
		if (scan_phase && rd_v_q && !valid_q[sidx_q] && !free_ok_q) free_slot_q <= sidx_q;
		if (ctl.load) begin
			cmd_q <= cmd;
			id_q <= req_id;
			side_q <= side;
			price_q <= price;
			qty_q <= quantity;
		end
	end

	always_comb begin
		status = st_q;
		bid_present = bb_v_q;
		ask_present = ba_v_q;
		best_bid_price = bb_v_q ? bb_p_q : '0;
		best_ask_price = ba_v_q ? ba_p_q : '0;
		best_bid_id = bb_v_q ? bb_id_q : '0;
		best_ask_id = ba_v_q ? ba_id_q : '0;
		spread_ticks = (bb_v_q && ba_v_q) ?
			(spread_t'(ba_p_q) - spread_t'(bb_p_q)) : '0;
		found_side = f_v_q ? f_side_q : 1'b0;
		found_price = f_v_q ? f_p_q : '0;
		found_quantity = f_v_q ? f_qty_q : '0;
	end
endmodule

// ----- sv/limit_order_book_engine_unit.sv -----
// ----------------------------------------------------------------------------
// limit_order_book_engine_unit
// price-time priority order book over a 256-slot order table
// ----------------------------------------------------------------------------
// Each request runs from start to done as one pass of reads over all 256
// slots of the table memory to find the id and the first free slot, an
// update step, a second pass over the table for best bid, best ask and the
// looked-up order, then the result. Both passes are set by the single read
// port of the table. The result is on the outputs for the one cycle that
// done is high and cannot be held off; busy is high from acceptance until then.
module limit_order_book_engine_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          cmd,
	input  logic [31:0]         req_id,
	input  logic                side,
	input  lobe_pkg::price_t    price,
	input  logic [31:0]         quantity,
	output logic                done,
	output logic [2:0]          status,
	output lobe_pkg::price_t    best_bid_price,
	output lobe_pkg::price_t    best_ask_price,
	output lobe_pkg::spread_t   spread_ticks,
	output logic                bid_present,
	output logic                ask_present,
	output logic [31:0]         best_bid_id,
	output logic [31:0]         best_ask_id,
	output logic                found_side,
	output lobe_pkg::price_t    found_price,
	output logic [31:0]         found_quantity
);
	import lobe_pkg::*;
	`include "limit_order_book_engine_unit_assert.svh"

	lobe_ctl_t ctl;
	lobe_sts_t sts;
	logic      two_sided;

	lobe_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.ctl(ctl), .sts(sts)
	);

	lobe_dp u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.cmd(cmd), .req_id(req_id), .side(side), .price(price),
		.quantity(quantity), .done(done), .status(status),
		.best_bid_price(best_bid_price), .best_ask_price(best_ask_price),
		.spread_ticks(spread_ticks), .bid_present(bid_present),
		.ask_present(ask_present), .best_bid_id(best_bid_id),
		.best_ask_id(best_ask_id), .found_side(found_side),
		.found_price(found_price), .found_quantity(found_quantity)
	);

	assign two_sided = bid_present && ask_present;

	`LOB_ASSERT(a_done_busy, clk, arst_n, done |-> $past(busy), "done without request")
	`LOB_ASSERT(a_done_free, clk, arst_n, done |=> !done, "double result")
	`LOB_ASSERT(a_spread_zero, clk, arst_n, (done && !two_sided) |-> spread_ticks == '0, "spread")
endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// drives add, cancel, modify and query requests into the order book engine
// and checks every result against a behavioural book held in the scoreboard
// ----------------------------------------------------------------------------
module tb_top;
	import lobe_pkg::*;

	class book_scoreboard;
		bit           slot_used [MaxOrders];
		logic [31:0]  slot_id [MaxOrders];
		logic         slot_side [MaxOrders];
		price_t       slot_price [MaxOrders];
		logic [31:0]  slot_qty [MaxOrders];
		arr_t         slot_arr [MaxOrders];
		arr_t         next_arr;

		logic [2:0]   exp_status [$];
		price_t       exp_bid [$];
		price_t       exp_ask [$];
		spread_t      exp_spread [$];
		logic         exp_bid_pres [$];
		logic         exp_ask_pres [$];
		logic [31:0]  exp_bid_id [$];
		logic [31:0]  exp_ask_id [$];
		logic         exp_fside [$];
		price_t       exp_fprice [$];
		logic [31:0]  exp_fqty [$];
		int           errors;

		function new();
			foreach (slot_used[i]) slot_used[i] = 0;
			next_arr = '0;
			errors = 0;
		endfunction

		function int find_order(logic [31:0] id);
			for (int i = 0; i < MaxOrders; i++)
				if (slot_used[i] && slot_id[i] == id) return i;
			return -1;
		endfunction

		function int count_orders();
			int n;
			n = 0;
			foreach (slot_used[i]) n += slot_used[i];
			return n;
		endfunction

		function int best_slot(logic sd);
			int b;
			bit better;
			b = -1;
			for (int i = 0; i < MaxOrders; i++) begin
				if (!slot_used[i] || slot_side[i] != sd) continue;
				if (b < 0) begin
					b = i;
					continue;
				end
				if (slot_price[i] == slot_price[b]) better = slot_arr[i] < slot_arr[b];
				else if (sd == 0) better = slot_price[i] > slot_price[b];
				else better = slot_price[i] < slot_price[b];
				if (better) b = i;
			end
			return b;
		endfunction

		function void note_request(logic [1:0] c, logic [31:0] id, logic sd, price_t p,
				logic [31:0] q);
			logic [2:0] st;
			int s, f, bb, ba;
			price_t bp, ap, fp;
			spread_t sp;
			logic [31:0] bid, aid, fq;
			logic bpr, apr, fs;
			st = ST_OK;
			s = find_order(id);
			case (c)
				CMD_ADD: begin
					if (s >= 0) st = ST_DUP;
					else begin
						f = -1;
						for (int i = MaxOrders - 1; i >= 0; i--) if (!slot_used[i]) f = i;
						if (f < 0) st = ST_FULL;
						else begin
							slot_used[f] = 1;
							slot_id[f] = id;
							slot_side[f] = sd;
							slot_price[f] = p;
							slot_qty[f] = q;
							slot_arr[f] = next_arr;
							next_arr++;
						end
					end
				end
				CMD_CANCEL: begin
					if (s < 0) st = ST_NOT_FOUND;
					else slot_used[s] = 0;
				end
				CMD_MODIFY: begin
					if (p < 0) st = ST_NEG_PRICE;
					else if (q == 0) st = ST_ZERO_QTY;
					else if (s < 0) st = ST_NOT_FOUND;
					else begin
						if (slot_price[s] != p) begin
							slot_price[s] = p;
							slot_arr[s] = next_arr;
							next_arr++;
						end
						slot_qty[s] = q;
					end
				end
				default: if (s < 0) st = ST_NOT_FOUND;
			endcase
			bb = best_slot(0);
			ba = best_slot(1);
			bp = bb >= 0 ? slot_price[bb] : '0;
			ap = ba >= 0 ? slot_price[ba] : '0;
			sp = (bb >= 0 && ba >= 0) ? spread_t'(ap) - spread_t'(bp) : '0;
			bpr = (bb >= 0);
			apr = (ba >= 0);
			bid = bb >= 0 ? slot_id[bb] : '0;
			aid = ba >= 0 ? slot_id[ba] : '0;
			s = find_order(id);
			fs = s >= 0 ? slot_side[s] : 1'b0;
			fp = s >= 0 ? slot_price[s] : '0;
			fq = s >= 0 ? slot_qty[s] : '0;
			exp_status = {exp_status, st};
			exp_bid = {exp_bid, bp};
			exp_ask = {exp_ask, ap};
			exp_spread = {exp_spread, sp};
			exp_bid_pres = {exp_bid_pres, bpr};
			exp_ask_pres = {exp_ask_pres, apr};
			exp_bid_id = {exp_bid_id, bid};
			exp_ask_id = {exp_ask_id, aid};
			exp_fside = {exp_fside, fs};
			exp_fprice = {exp_fprice, fp};
			exp_fqty = {exp_fqty, fq};
		endfunction

		function void cmp(string name, logic [63:0] e, logic [63:0] a);
			if (e !== a) begin
				$error("%s expected %0h actual %0h", name, e, a);
				errors++;
			end
		endfunction

		function void check_result(logic [2:0] st, price_t bp, price_t ap, spread_t sp,
				logic bpr, logic apr, logic [31:0] bid, logic [31:0] aid, logic fs,
				price_t fp, logic [31:0] fq);
			if (exp_status.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
				return;
			end
			cmp("status", exp_status.pop_front(), st);
			cmp("best_bid_price", exp_bid.pop_front(), bp);
			cmp("best_ask_price", exp_ask.pop_front(), ap);
			cmp("spread_ticks", exp_spread.pop_front(), sp);
			cmp("bid_present", exp_bid_pres.pop_front(), bpr);
			cmp("ask_present", exp_ask_pres.pop_front(), apr);
			cmp("best_bid_id", exp_bid_id.pop_front(), bid);
			cmp("best_ask_id", exp_ask_id.pop_front(), aid);
			cmp("found_side", exp_fside.pop_front(), fs);
			cmp("found_price", exp_fprice.pop_front(), fp);
			cmp("found_quantity", exp_fqty.pop_front(), fq);
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic [1:0]  cmd = CMD_ADD;
	logic [31:0] req_id = '0;
	logic        side = 0;
	price_t      price = '0;
	logic [31:0] quantity = '0;
	logic        busy, done, bid_present, ask_present, found_side;
	logic [2:0]  status;
	price_t      best_bid_price, best_ask_price, found_price;
	spread_t     spread_ticks;
	logic [31:0] best_bid_id, best_ask_id, found_quantity;

	book_scoreboard book = new();
	logic [31:0] id_pool [$];

	limit_order_book_engine_unit uut (.*);

	always #5 clk = ~clk;

	always @(posedge clk)
		if (done)
			book.check_result(status, best_bid_price, best_ask_price, spread_ticks,
				bid_present, ask_present, best_bid_id, best_ask_id, found_side,
				found_price, found_quantity);

	// far above the run time of 500 requests plus gaps
	initial begin
		#20000000;
		$display("tb_top failed");
		$finish;
	end

	task automatic send(logic [1:0] c, logic [31:0] id, logic sd, price_t p,
			logic [31:0] q);
		int gap;
		gap = $urandom_range(0, 10);
		repeat (gap) @(posedge clk);
		start <= 1;
		cmd <= c;
		req_id <= id;
		side <= sd;
		price <= p;
		quantity <= q;
		// accepting edge: busy as seen just before the edge is low
		@(posedge clk iff !busy);
		book.note_request(c, id, sd, p, q);
		start <= 0;
		if (c == CMD_ADD) id_pool = {id_pool, id};
		@(posedge clk);
	endtask

	task automatic drain();
		while (book.exp_status.size() != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_id();
		if (id_pool.size() == 0 || $urandom_range(0, 9) == 0) return $urandom;
		return id_pool[$urandom_range(0, id_pool.size() - 1)];
	endfunction

	function automatic price_t near_price();
		return price_t'($signed($urandom_range(0, 40)) - 20);
	endfunction

	initial begin
		logic [1:0] c;
		int n;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: empty book, extremes, every status except full
		send(CMD_QUERY, 32'h0, 0, '0, '0);
		send(CMD_ADD, 32'hFFFFFFFF, 0, 24'sh7FFFFF, 32'hFFFFFFFF);
		send(CMD_ADD, 32'h0, 1, 24'sh800000, 32'h0);
		send(CMD_ADD, 32'hFFFFFFFF, 1, 24'sh1, 32'h5);
		send(CMD_ADD, 32'h1, 0, 24'sh7FFFFF, 32'h1);
		send(CMD_QUERY, 32'h0, 0, '0, '0);
		send(CMD_MODIFY, 32'hFFFFFFFF, 0, 24'sh7FFFFF, 32'h7);
		send(CMD_MODIFY, 32'h1, 0, 24'sh800000, 32'h7);
		send(CMD_MODIFY, 32'h1, 0, 24'sh10, 32'h0);
		send(CMD_MODIFY, 32'h12345678, 0, 24'sh10, 32'h3);
		send(CMD_MODIFY, 32'hFFFFFFFF, 0, 24'sh0, 32'hAAAAAAAA);
		send(CMD_MODIFY, 32'hFFFFFFFF, 0, 24'sh7FFFFF, 32'h55555555);
		send(CMD_CANCEL, 32'h0, 0, '0, '0);
		send(CMD_CANCEL, 32'h0, 0, '0, '0);
		send(CMD_ADD, 32'h2, 1, 24'sh7FFFFF, 32'h9);
		send(CMD_ADD, 32'h3, 0, 24'sh800000, 32'h9);
		send(CMD_QUERY, 32'h3, 1, 24'sh5, 32'h1);
		send(CMD_CANCEL, 32'h1, 0, '0, '0);
		send(CMD_CANCEL, 32'hFFFFFFFF, 0, '0, '0);
		send(CMD_CANCEL, 32'h2, 0, '0, '0);
		send(CMD_CANCEL, 32'h3, 0, '0, '0);
		drain();
		id_pool.delete();
		// random traffic around a narrow price band
		for (int i = 0; i < 150; i++) begin
			if (i == 75) drain();
			n = $urandom_range(0, 99);
			c = n < 40 ? CMD_ADD : n < 60 ? CMD_CANCEL : n < 85 ? CMD_MODIFY : CMD_QUERY;
			send(c, pick_id(), 1'($urandom), $urandom_range(0, 19) == 0 ?
				price_t'($urandom) : near_price(),
				$urandom_range(0, 9) == 0 ? 32'h0 : $urandom);
		end
		// fill the table, then full and duplicate adds, a cancel, a re-add and a query
		while (book.count_orders() < MaxOrders)
			send(CMD_ADD, $urandom, 1'($urandom), near_price(), $urandom);
		send(CMD_ADD, 32'hCAFE0001, 0, 24'sh5, 32'h1);
		send(CMD_ADD, id_pool[0], 1, 24'sh5, 32'h1);
		send(CMD_CANCEL, id_pool[$], 0, '0, '0);
		send(CMD_ADD, 32'hCAFE0002, 1, 24'sh5, 32'h1);
		send(CMD_QUERY, 32'hCAFE0002, 0, '0, '0);
		drain();
		repeat (600) @(posedge clk);
		if (book.errors == 0 && book.exp_status.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+sv
sv/lobe_pkg.sv
sv/lobe_ctrl.sv
sv/lobe_dp.sv
sv/limit_order_book_engine_unit.sv
verif/tb_top.sv
